// ===== design/elevator_next_stop_selector_macros.svh =====
// ----------------------------------------------------------------------------
// Elevator next-stop selector assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_NEXT_STOP_SELECTOR_MACROS_SVH
`define ELEVATOR_NEXT_STOP_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define ENSC_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("elevator_next_stop_selector assertion failed");

// Checked at every clock edge, reset included.
`define ENSC_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("elevator_next_stop_selector assertion failed");

`else

`define ENSC_ASSERT_RST(lbl, clk, rstn, prop)
`define ENSC_ASSERT_CLK(lbl, clk, prop)

`endif

`endif

// ===== design/ensc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elevator next-stop selector package
// Shared widths, codes and the scan result type.
// ----------------------------------------------------------------------------
package ensc_pkg;

    localparam int FLOORS  = 16;
    localparam int MASK_W  = 16;
    localparam int FLOOR_W = 4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] MST_OTHER = 2'd3;

    // Result of the nearest-request search on both sides of the car.
    typedef struct packed {
        logic               here;
        logic               above_found;
        logic [FLOOR_W-1:0] above_floor;
        logic               below_found;
        logic [FLOOR_W-1:0] below_floor;
    } scan_t;

    // Floors that exist in the building; mask bits beyond them are dropped.
    function automatic logic [MASK_W-1:0] valid_floor_mask();
        logic [MASK_W-1:0] m;
        for (int f = 0; f < MASK_W; f++) begin
            m[f] = (f < FLOORS);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== design/ensc_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Elevator request scan
// Finds the nearest request strictly above and strictly below the car floor.
// ----------------------------------------------------------------------------
module ensc_scan
    import ensc_pkg::*;
(
    input  wire logic [MASK_W-1:0]  req,
    input  wire logic [FLOOR_W-1:0] cur,
    output scan_t                   res
);

    logic [MASK_W-1:0] above;
    logic [MASK_W-1:0] below;

    always_comb begin
        for (int f = 0; f < MASK_W; f++) begin
            above[f] = req[f] && (FLOOR_W'(f) > cur);
            below[f] = req[f] && (FLOOR_W'(f) < cur);
        end
    end

    // Lowest set bit above the car, highest set bit below it.
    always_comb begin
        res = '0;
        res.here = req[cur];
        for (int f = MASK_W - 1; f >= 0; f--) begin
            if (above[f]) begin
                res.above_found = 1'b1;
                res.above_floor = FLOOR_W'(f);
            end
        end
        for (int f = 0; f < MASK_W; f++) begin
            if (below[f]) begin
                res.below_found = 1'b1;
                res.below_floor = FLOOR_W'(f);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/elevator_next_stop_selector.sv =====
// Throughput: one item per cycle while the output is not stalled; the three
// stages (request merge, nearest search, target choice) each hold one item
// and advance independently. Reset (aresetn low, synchronous) empties all
// stages; payload is not cleared.
`default_nettype none
`include "elevator_next_stop_selector_macros.svh"
// ----------------------------------------------------------------------------
// Elevator next-stop selector
// Collective-control scan: next target floor, stop and stopped flags.
// ----------------------------------------------------------------------------
module elevator_next_stop_selector
    import ensc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // current_floor[3:0], direction[5:4], motion_state[7:6], query_floor[11:8],
    // cabin_mask[27:12], hall_up_mask[43:28], hall_down_mask[59:44], zero[63:60]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // target_floor[3:0], target_valid[4], stop_here[5], stopped_here[6], zero[7]
    output logic [7:0]       m_tdata
);

    logic [FLOOR_W-1:0] in_cur;
    logic [1:0]         in_dir;
    logic [1:0]         in_mst;
    logic [FLOOR_W-1:0] in_qf;
    logic [MASK_W-1:0]  in_cab;
    logic [MASK_W-1:0]  in_hup;
    logic [MASK_W-1:0]  in_hdn;

    assign in_cur = s_tdata[3:0];
    assign in_dir = s_tdata[5:4];
    assign in_mst = s_tdata[7:6];
    assign in_qf  = s_tdata[11:8];
    assign in_cab = s_tdata[27:12] & valid_floor_mask();
    assign in_hup = s_tdata[43:28] & valid_floor_mask();
    assign in_hdn = s_tdata[59:44] & valid_floor_mask();

    logic rdy1;
    logic rdy2;
    logic rdy3;

    // Stage 1: merged requests and the query flags.
    logic               v1_reg;
    logic [MASK_W-1:0]  req1_reg;
    logic [FLOOR_W-1:0] cur1_reg;
    logic [1:0]         dir1_reg;
    logic               stop1_reg;
    logic               stopped1_reg;
    logic               stop_next;
    logic               stopped_next;

    // Stage 2: nearest requests on either side.
    logic               v2_reg;
    scan_t              scan_next;
    scan_t              scan2_reg;
    logic [FLOOR_W-1:0] cur2_reg;
    logic [1:0]         dir2_reg;
    logic               stop2_reg;
    logic               stopped2_reg;

    // Stage 3: output register.
    logic               v3_reg;
    logic [FLOOR_W-1:0] target_next;
    logic               found_next;
    logic [FLOOR_W-1:0] target3_reg;
    logic               found3_reg;
    logic               stop3_reg;
    logic               stopped3_reg;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign stop_next = in_cab[in_qf]
                    || (in_hup[in_qf] && (in_dir == DIR_UP))
                    || (in_hdn[in_qf] && (in_dir == DIR_DOWN));
    assign stopped_next = (in_qf == in_cur) && (in_mst != MST_OTHER);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
        if (rdy1 && s_tvalid) begin
            req1_reg     <= in_cab | in_hup | in_hdn;
            cur1_reg     <= in_cur;
            dir1_reg     <= in_dir;
            stop1_reg    <= stop_next;
            stopped1_reg <= stopped_next;
        end
    end

    ensc_scan u_scan (
        .req (req1_reg),
        .cur (cur1_reg),
        .res (scan_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2 && v1_reg) begin
            scan2_reg    <= scan_next;
            cur2_reg     <= cur1_reg;
            dir2_reg     <= dir1_reg;
            stop2_reg    <= stop1_reg;
            stopped2_reg <= stopped1_reg;
        end
    end

    // Direction of travel wins, then a request at the car floor, then the nearest
    // request; a tie between a floor below and one above goes to the one below.
    always_comb begin
        logic [FLOOR_W-1:0] dist_up;
        logic [FLOOR_W-1:0] dist_dn;
        dist_up     = scan2_reg.above_floor - cur2_reg;
        dist_dn     = cur2_reg - scan2_reg.below_floor;
        found_next  = scan2_reg.here || scan2_reg.above_found || scan2_reg.below_found;
        target_next = '0;
        if ((dir2_reg == DIR_UP) && scan2_reg.above_found) begin
            target_next = scan2_reg.above_floor;
        end else if ((dir2_reg == DIR_DOWN) && scan2_reg.below_found) begin
            target_next = scan2_reg.below_floor;
        end else if (scan2_reg.here) begin
            target_next = cur2_reg;
        end else if (scan2_reg.below_found
                     && (!scan2_reg.above_found || (dist_dn <= dist_up))) begin
            target_next = scan2_reg.below_floor;
        end else if (scan2_reg.above_found) begin
            target_next = scan2_reg.above_floor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (rdy3 && v2_reg) begin
            target3_reg  <= target_next;
            found3_reg   <= found_next;
            stop3_reg    <= stop2_reg;
            stopped3_reg <= stopped2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {1'b0, stopped3_reg, stop3_reg, found3_reg, target3_reg};

    `ENSC_ASSERT_CLK(a_reset_empties, aclk, !aresetn |=> !m_tvalid)
    `ENSC_ASSERT_RST(a_empty_out_accepts, aclk, aresetn, !m_tvalid |-> s_tready)
    `ENSC_ASSERT_RST(a_above_is_above, aclk, aresetn,
        (v2_reg && scan2_reg.above_found) |-> (scan2_reg.above_floor > cur2_reg))
    `ENSC_ASSERT_RST(a_below_is_below, aclk, aresetn,
        (v2_reg && scan2_reg.below_found) |-> (scan2_reg.below_floor < cur2_reg))
    `ENSC_ASSERT_RST(a_no_target_zero, aclk, aresetn,
        (m_tvalid && !found3_reg) |-> (target3_reg == '0))

endmodule
`default_nettype wire
